// ===== rtl/spi_link_session_master_assert.svh =====
// Assertion macros used by the checker file of the SPI link session master.
`ifndef SPI_LINK_SESSION_MASTER_ASSERT_SVH
`define SPI_LINK_SESSION_MASTER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define SLS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sls check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define SLS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sls check failed");

`endif

// ===== rtl/sls_pkg.sv =====
// Types and constants of the SPI link session master.
`timescale 1ns / 1ps
package sls_pkg;

   localparam logic [1:0] OP_DECIDE     = 2'd0;
   localparam logic [1:0] OP_DIGEST     = 2'd1;
   localparam logic [1:0] OP_RESET_DONE = 2'd2;

   localparam logic [2:0] CMD_NONE     = 3'd0;
   localparam logic [2:0] CMD_HELLO    = 3'd1;
   localparam logic [2:0] CMD_RF_QUERY = 3'd2;
   localparam logic [2:0] CMD_IRQ_ACK  = 3'd3;
   localparam logic [2:0] CMD_PING     = 3'd4;

   localparam logic [1:0] LINK_WAIT     = 2'd0;
   localparam logic [1:0] LINK_UP       = 2'd1;
   localparam logic [1:0] LINK_RECOVERY = 2'd2;

   localparam logic [3:0] STATUS_OK           = 4'd0;
   localparam logic [3:0] STATUS_UNKNOWN_TYPE = 4'd8;

   localparam logic [2:0] MSG_HELLO      = 3'd0;
   localparam logic [2:0] MSG_RX_DESC    = 3'd1;
   localparam logic [2:0] MSG_RX_CHUNK   = 3'd2;
   localparam logic [2:0] MSG_QUEUE_FULL = 3'd3;
   localparam logic [2:0] MSG_ERROR      = 3'd4;

   localparam logic [7:0] ASYNC_ERROR_MIN = 8'h04;

   localparam logic [2:0] REG_HELLO_RETRY_INTERVAL = 3'd0;
   localparam logic [2:0] REG_HELLO_TRY_LIMIT      = 3'd1;
   localparam logic [2:0] REG_STALL_LIMIT          = 3'd2;
   localparam logic [2:0] REG_SPURIOUS_IRQ_WINDOW  = 3'd3;
   localparam logic [2:0] REG_SILENCE_WATCHDOG     = 3'd4;
   localparam logic [2:0] REG_PING_INTERVAL        = 3'd5;

   localparam logic [31:0] HELLO_RETRY_INTERVAL_RESET = 32'd500000;
   localparam logic [7:0]  HELLO_TRY_LIMIT_RESET      = 8'd10;
   localparam logic [7:0]  STALL_LIMIT_RESET          = 8'd8;
   localparam logic [31:0] SPURIOUS_IRQ_WINDOW_RESET  = 32'd1000000;
   localparam logic [31:0] SILENCE_WATCHDOG_RESET     = 32'd3000000;
   localparam logic [31:0] PING_INTERVAL_RESET        = 32'd1000000;

   typedef enum logic [2:0] {
      ST_WAIT     = 3'b001,
      ST_UP       = 3'b010,
      ST_RECOVERY = 3'b100
   } session_type;

   typedef struct packed {
      logic [31:0] hello_retry_interval;
      logic [7:0]  hello_try_limit;
      logic [7:0]  stall_limit;
      logic [31:0] spurious_irq_window;
      logic [31:0] silence_watchdog;
      logic [31:0] ping_interval;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  operation;
      logic [31:0] now_time;
      logic        irq_level;
      logic [31:0] transfer_time;
      logic [3:0]  frame_status;
      logic [2:0]  message_kind;
      logic        body_valid;
      logic [7:0]  error_number;
      logic [15:0] event_sequence;
      logic        payload_complete;
   } item_type;

   typedef struct packed {
      session_type session;
      logic [15:0] next_command_seq;
      logic [7:0]  hello_count;
      logic [31:0] last_hello_time;
      logic [31:0] last_legal_time;
      logic [31:0] last_ping_time;
      logic [31:0] last_event_time;
      logic [31:0] irq_high_since;
      logic [31:0] local_time;
      logic [7:0]  stall_counter;
      logic [15:0] last_event_seq;
      logic        event_seq_known;
      logic        rf_query_pending;
      logic        payload_delivered;
      logic        reset_pending;
   } ctx_type;

   typedef struct packed {
      logic [2:0]  command;
      logic [15:0] command_sequence;
      logic [1:0]  link_state;
      logic        reset_request;
      logic        deliver_payload;
      logic        gap_seen;
      logic        event_transaction;
      logic [7:0]  stall_count;
   } result_type;

   localparam cfg_type CFG_RESET = '{
      hello_retry_interval: HELLO_RETRY_INTERVAL_RESET,
      hello_try_limit:      HELLO_TRY_LIMIT_RESET,
      stall_limit:          STALL_LIMIT_RESET,
      spurious_irq_window:  SPURIOUS_IRQ_WINDOW_RESET,
      silence_watchdog:     SILENCE_WATCHDOG_RESET,
      ping_interval:        PING_INTERVAL_RESET
   };

   localparam ctx_type CTX_RESET = '{
      session:           ST_WAIT,
      next_command_seq:  16'd0,
      hello_count:       8'd0,
      last_hello_time:   32'd0 - HELLO_RETRY_INTERVAL_RESET,
      last_legal_time:   32'd0,
      last_ping_time:    32'd0,
      last_event_time:   32'd0,
      irq_high_since:    32'd0,
      local_time:        32'd0,
      stall_counter:     8'd0,
      last_event_seq:    16'd0,
      event_seq_known:   1'b0,
      rf_query_pending:  1'b0,
      payload_delivered: 1'b0,
      reset_pending:     1'b0
   };

endpackage

// ===== rtl/sls_step.sv =====
// Next-state and result logic for one item of the SPI link session master.
`timescale 1ns / 1ps
module sls_step (
   input  sls_pkg::cfg_type    cfg,
   input  sls_pkg::ctx_type    ctx,
   input  sls_pkg::item_type   item,
   output sls_pkg::ctx_type    ctx_next,
   output sls_pkg::result_type result
);

   logic [31:0] since_irq;
   logic [31:0] since_event;
   logic [31:0] since_legal;
   logic [31:0] since_hello;
   logic [31:0] since_ping;
   logic [31:0] digest_time;
   logic        stalled;
   logic        spurious;
   logic        silent;
   logic        to_recovery;
   logic        seq_gap;
   logic        body_event;

   assign since_irq   = item.now_time - ctx.irq_high_since;
   assign since_event = item.now_time - ctx.last_event_time;
   assign since_legal = item.now_time - ctx.last_legal_time;
   assign since_hello = item.now_time - ctx.last_hello_time;
   assign since_ping  = item.now_time - ctx.last_ping_time;
   assign digest_time = ctx.local_time + item.transfer_time;

   assign stalled  = item.irq_level && (ctx.stall_counter >= cfg.stall_limit);
   assign spurious = item.irq_level && (ctx.irq_high_since != 32'd0) &&
                     (since_irq > cfg.spurious_irq_window) &&
                     (since_event > cfg.spurious_irq_window);
   assign silent   = (ctx.irq_high_since == 32'd0) && (since_legal > cfg.silence_watchdog);
   assign to_recovery = (ctx.session == sls_pkg::ST_UP) && (stalled || spurious || silent);

   // Gap: not the successor of the last event sequence, once a baseline exists.
   assign seq_gap = ctx.event_seq_known && ((ctx.last_event_seq + 16'd1) != item.event_sequence);

   // Reply kinds that carry a sequenced event.
   assign body_event = item.body_valid && ((item.message_kind == sls_pkg::MSG_RX_DESC) ||
                       (item.message_kind == sls_pkg::MSG_RX_CHUNK) ||
                       (item.message_kind == sls_pkg::MSG_QUEUE_FULL));

   always_comb begin
      ctx_next = ctx;
      result   = '0;
      result.command = sls_pkg::CMD_NONE;

      unique case (item.operation)
         sls_pkg::OP_DECIDE: begin
            ctx_next.local_time = item.now_time;
            if (to_recovery) begin
               ctx_next.session       = sls_pkg::ST_RECOVERY;
               ctx_next.reset_pending = 1'b1;
            end else begin
               if (item.irq_level) begin
                  if (ctx.irq_high_since == 32'd0) begin
                     ctx_next.irq_high_since = item.now_time;
                  end
               end else begin
                  ctx_next.irq_high_since = 32'd0;
                  ctx_next.stall_counter  = 8'd0;
               end
               unique case (ctx.session)
                  sls_pkg::ST_WAIT: begin
                     if (ctx.hello_count >= cfg.hello_try_limit) begin
                        ctx_next.session       = sls_pkg::ST_RECOVERY;
                        ctx_next.reset_pending = 1'b1;
                     end else if (since_hello >= cfg.hello_retry_interval) begin
                        result.command          = sls_pkg::CMD_HELLO;
                        ctx_next.last_hello_time = item.now_time;
                        ctx_next.hello_count     = ctx.hello_count + 8'd1;
                     end
                  end
                  sls_pkg::ST_UP: begin
                     if (ctx.rf_query_pending) begin
                        result.command            = sls_pkg::CMD_RF_QUERY;
                        ctx_next.rf_query_pending = 1'b0;
                     end else if (item.irq_level) begin
                        result.command = sls_pkg::CMD_IRQ_ACK;
                     end else if (since_ping >= cfg.ping_interval) begin
                        result.command          = sls_pkg::CMD_PING;
                        ctx_next.last_ping_time = item.now_time;
                     end
                  end
                  default: begin
                  end
               endcase
            end
            if (result.command != sls_pkg::CMD_NONE) begin
               result.command_sequence   = ctx.next_command_seq;
               ctx_next.next_command_seq = ctx.next_command_seq + 16'd1;
            end
         end

         sls_pkg::OP_DIGEST: begin
            ctx_next.local_time = digest_time;
            if (item.frame_status == sls_pkg::STATUS_OK) begin
               ctx_next.last_legal_time = digest_time;
               if (item.message_kind == sls_pkg::MSG_HELLO) begin
                  if (item.body_valid) begin
                     ctx_next.hello_count = 8'd0;
                     if (ctx.session == sls_pkg::ST_WAIT) begin
                        ctx_next.event_seq_known  = 1'b0;
                        ctx_next.rf_query_pending = 1'b1;
                        ctx_next.stall_counter    = 8'd0;
                        ctx_next.last_ping_time   = digest_time;
                        ctx_next.session          = sls_pkg::ST_UP;
                     end
                  end
               end else if (body_event) begin
                  result.gap_seen          = seq_gap;
                  result.event_transaction = 1'b1;
                  ctx_next.last_event_seq  = item.event_sequence;
                  ctx_next.event_seq_known = 1'b1;
                  if (item.message_kind == sls_pkg::MSG_RX_DESC) begin
                     ctx_next.payload_delivered = 1'b0;
                  end
                  if ((item.message_kind == sls_pkg::MSG_RX_CHUNK) &&
                      !ctx.payload_delivered && item.payload_complete) begin
                     ctx_next.payload_delivered = 1'b1;
                     result.deliver_payload     = 1'b1;
                  end
               end else if ((item.message_kind == sls_pkg::MSG_ERROR) && item.body_valid &&
                            (item.error_number >= sls_pkg::ASYNC_ERROR_MIN)) begin
                  // Asynchronous errors are events but carry no checked sequence.
                  result.event_transaction = 1'b1;
               end
            end else if (item.frame_status == sls_pkg::STATUS_UNKNOWN_TYPE) begin
               ctx_next.last_legal_time = digest_time;
            end
            if (result.event_transaction) begin
               ctx_next.stall_counter   = 8'd0;
               ctx_next.last_event_time = digest_time;
            end else begin
               ctx_next.stall_counter = ctx_next.stall_counter + 8'd1;
            end
         end

         sls_pkg::OP_RESET_DONE: begin
            ctx_next.reset_pending    = 1'b0;
            ctx_next.session          = sls_pkg::ST_WAIT;
            ctx_next.hello_count      = 8'd0;
            ctx_next.last_hello_time  = item.now_time - cfg.hello_retry_interval;
            ctx_next.last_legal_time  = item.now_time;
            ctx_next.event_seq_known  = 1'b0;
            ctx_next.rf_query_pending = 1'b0;
            ctx_next.stall_counter    = 8'd0;
            ctx_next.irq_high_since   = 32'd0;
            ctx_next.local_time       = item.now_time;
         end

         default: begin
         end
      endcase

      unique case (ctx_next.session)
         sls_pkg::ST_WAIT:     result.link_state = sls_pkg::LINK_WAIT;
         sls_pkg::ST_UP:       result.link_state = sls_pkg::LINK_UP;
         sls_pkg::ST_RECOVERY: result.link_state = sls_pkg::LINK_RECOVERY;
         default:              result.link_state = sls_pkg::LINK_RECOVERY;
      endcase
      result.reset_request = ctx_next.reset_pending;
      result.stall_count   = ctx_next.stall_counter;
   end

endmodule

// ===== rtl/spi_link_session_master.sv =====
// Top level of the SPI link session master: channels, registers and configuration.
`timescale 1ns / 1ps
// Usage:
// Each request beat (req_*) carries one operation: decide the next command,
// digest a decoded reply, or report that the slave reset pulse is done. Every
// request beat yields exactly one response beat (rsp_*) with the command to
// send, its sequence number, the link state and the status flags.
// A beat moves when valid is high and stall is low at a rising clock edge.
// The request is captured in an input register, and the session logic then
// evaluates it against the session state and writes the response register
// together with the new state. Throughput is one beat per cycle while the
// receiver does not stall; the session state is updated in the same cycle
// that the response is formed, so the next request sees it at once. When the
// receiver stalls, the response register holds its beat and the input
// register can still take one more request; beyond that req_stall is raised
// until the response drains. The configuration registers are written through
// csr_*; the user must write them only while the block is idle, which the
// block does not enforce. Synchronous reset empties both registers, restores
// the register defaults and puts the session back in the wait-for-hello state.
module spi_link_session_master (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [31:0] req_now_time,
   input  logic        req_irq_level,
   input  logic [31:0] req_transfer_time,
   input  logic [3:0]  req_frame_status,
   input  logic [2:0]  req_message_kind,
   input  logic        req_body_valid,
   input  logic [7:0]  req_error_number,
   input  logic [15:0] req_event_sequence,
   input  logic        req_payload_complete,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_command,
   output logic [15:0] rsp_command_sequence,
   output logic [1:0]  rsp_link_state,
   output logic        rsp_reset_request,
   output logic        rsp_deliver_payload,
   output logic        rsp_gap_seen,
   output logic        rsp_event_transaction,
   output logic [7:0]  rsp_stall_count,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   sls_pkg::cfg_type    cfg_ff, cfg_in;
   sls_pkg::ctx_type    ctx_ff, ctx_in, ctx_step;
   sls_pkg::item_type   item_ff, item_in, req_item;
   sls_pkg::result_type result_ff, result_in, result_step;
   logic                item_valid_ff, item_valid_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                req_take;
   logic                advance;

   assign req_item = '{
      operation:        req_operation,
      now_time:         req_now_time,
      irq_level:        req_irq_level,
      transfer_time:    req_transfer_time,
      frame_status:     req_frame_status,
      message_kind:     req_message_kind,
      body_valid:       req_body_valid,
      error_number:     req_error_number,
      event_sequence:   req_event_sequence,
      payload_complete: req_payload_complete
   };

   // The held item moves on when the response register is empty or draining.
   assign advance   = item_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = item_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   sls_step u_step (
      .cfg      (cfg_ff),
      .ctx      (ctx_ff),
      .item     (item_ff),
      .ctx_next (ctx_step),
      .result   (result_step)
   );

   always_comb begin
      item_valid_in = req_take || (item_valid_ff && !advance);
      item_in       = req_take ? req_item : item_ff;
      ctx_in        = advance ? ctx_step : ctx_ff;
      result_in     = advance ? result_step : result_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   // Register writes; an index beyond the list is ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            sls_pkg::REG_HELLO_RETRY_INTERVAL: cfg_in.hello_retry_interval = csr_data;
            sls_pkg::REG_HELLO_TRY_LIMIT:      cfg_in.hello_try_limit      = csr_data[7:0];
            sls_pkg::REG_STALL_LIMIT:          cfg_in.stall_limit          = csr_data[7:0];
            sls_pkg::REG_SPURIOUS_IRQ_WINDOW:  cfg_in.spurious_irq_window  = csr_data;
            sls_pkg::REG_SILENCE_WATCHDOG:     cfg_in.silence_watchdog     = csr_data;
            sls_pkg::REG_PING_INTERVAL:        cfg_in.ping_interval        = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         ctx_ff        <= sls_pkg::CTX_RESET;
         cfg_ff        <= sls_pkg::CFG_RESET;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         ctx_ff        <= ctx_in;
         cfg_ff        <= cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      result_ff <= result_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_command           = result_ff.command;
   assign rsp_command_sequence  = result_ff.command_sequence;
   assign rsp_link_state        = result_ff.link_state;
   assign rsp_reset_request     = result_ff.reset_request;
   assign rsp_deliver_payload   = result_ff.deliver_payload;
   assign rsp_gap_seen          = result_ff.gap_seen;
   assign rsp_event_transaction = result_ff.event_transaction;
   assign rsp_stall_count       = result_ff.stall_count;

endmodule

// ===== rtl/sls_checker.sv =====
// Port-level checker of the SPI link session master, bound to the top level.
`timescale 1ns / 1ps
`include "spi_link_session_master_assert.svh"
module sls_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [2:0]  rsp_command,
   input logic [15:0] rsp_command_sequence,
   input logic [1:0]  rsp_link_state,
   input logic        rsp_reset_request,
   input logic        rsp_deliver_payload,
   input logic        rsp_gap_seen,
   input logic        rsp_event_transaction,
   input logic [7:0]  rsp_stall_count
);

   // A response beat that is held back stays offered.
   `SLS_ASSERT_NEXT(a_rsp_held, clock, reset, rsp_valid && rsp_stall, rsp_valid)

   // Without a command there is no command sequence number.
   `SLS_ASSERT_IMPLY(a_no_cmd_seq, clock, reset, rsp_valid && (rsp_command == sls_pkg::CMD_NONE), rsp_command_sequence == 16'd0)

   // Recovery always goes with a pending slave reset request.
   `SLS_ASSERT_IMPLY(a_recovery_reset, clock, reset, rsp_valid && (rsp_link_state == sls_pkg::LINK_RECOVERY), rsp_reset_request)

   // Delivery and gap flags only come with an event, and an event clears the stall count.
   `SLS_ASSERT_IMPLY(a_event_flags, clock, reset, rsp_valid && (rsp_deliver_payload || rsp_gap_seen), rsp_event_transaction)
   `SLS_ASSERT_IMPLY(a_event_stall, clock, reset, rsp_valid && rsp_event_transaction, rsp_stall_count == 8'd0)

endmodule

bind spi_link_session_master sls_checker u_sls_checker (
   .clock                 (clock),
   .reset                 (reset),
   .rsp_valid             (rsp_valid),
   .rsp_stall             (rsp_stall),
   .rsp_command           (rsp_command),
   .rsp_command_sequence  (rsp_command_sequence),
   .rsp_link_state        (rsp_link_state),
   .rsp_reset_request     (rsp_reset_request),
   .rsp_deliver_payload   (rsp_deliver_payload),
   .rsp_gap_seen          (rsp_gap_seen),
   .rsp_event_transaction (rsp_event_transaction),
   .rsp_stall_count       (rsp_stall_count)
);

// ===== dv/tb_spi_link_session_master.sv =====
// Self-checking testbench of the SPI link session master with a built-in session predictor.
`timescale 1ns / 1ps
module tb_spi_link_session_master;

   // Codes that the package leaves out but that the stimulus must reach.
   localparam logic [1:0] OP_UNUSED          = 2'd3;
   localparam logic [3:0] STATUS_ILLEGAL_TOP = 4'd15;
   localparam logic [2:0] MSG_OTHER          = 3'd6;
   localparam logic [2:0] MSG_UNDEFINED      = 3'd7;

   // The predictor's own picture of the session, kept at the block's widths.
   typedef struct packed {
      logic [1:0]  link;
      logic [15:0] next_cmd_seq;
      logic [7:0]  hello_count;
      logic [31:0] last_hello_time;
      logic [31:0] last_legal_time;
      logic [31:0] last_ping_time;
      logic [31:0] last_event_time;
      logic [31:0] irq_high_since;
      logic [31:0] local_time;
      logic [7:0]  stall_counter;
      logic [15:0] last_evt_seq;
      logic        seq_known;
      logic        rf_query_pending;
      logic        payload_delivered;
      logic        reset_pending;
   } session_model_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   sls_pkg::item_type   req_item = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [2:0]          rsp_command;
   logic [15:0]         rsp_command_sequence;
   logic [1:0]          rsp_link_state;
   logic                rsp_reset_request;
   logic                rsp_deliver_payload;
   logic                rsp_gap_seen;
   logic                rsp_event_transaction;
   logic [7:0]          rsp_stall_count;
   logic                csr_write = 1'b0;
   logic [2:0]          csr_index = sls_pkg::REG_HELLO_RETRY_INTERVAL;
   logic [31:0]         csr_data = '0;

   // Requests waiting to be driven, and the responses that the accepted ones must produce.
   sls_pkg::item_type   request_backlog[$];
   sls_pkg::result_type expected_rsp[$];
   session_model_type   model;
   sls_pkg::cfg_type    model_cfg;
   int unsigned         fail_count = 0;

   // Percentages of cycles in which the sender holds back a beat and the receiver stalls.
   int unsigned req_gap_pct = 0;
   int unsigned rsp_hold_pct = 0;

   // Running microsecond clock and event sequence of the generated traffic.
   logic [31:0] clock_us = '0;
   logic [15:0] seq_cursor = '0;

   wire [1:0]  req_operation;
   wire [31:0] req_now_time;
   wire        req_irq_level;
   wire [31:0] req_transfer_time;
   wire [3:0]  req_frame_status;
   wire [2:0]  req_message_kind;
   wire        req_body_valid;
   wire [7:0]  req_error_number;
   wire [15:0] req_event_sequence;
   wire        req_payload_complete;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   assign req_operation        = req_item.operation;
   assign req_now_time         = req_item.now_time;
   assign req_irq_level        = req_item.irq_level;
   assign req_transfer_time    = req_item.transfer_time;
   assign req_frame_status     = req_item.frame_status;
   assign req_message_kind     = req_item.message_kind;
   assign req_body_valid       = req_item.body_valid;
   assign req_error_number     = req_item.error_number;
   assign req_event_sequence   = req_item.event_sequence;
   assign req_payload_complete = req_item.payload_complete;

   spi_link_session_master dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_operation        (req_operation),
      .req_now_time         (req_now_time),
      .req_irq_level        (req_irq_level),
      .req_transfer_time    (req_transfer_time),
      .req_frame_status     (req_frame_status),
      .req_message_kind     (req_message_kind),
      .req_body_valid       (req_body_valid),
      .req_error_number     (req_error_number),
      .req_event_sequence   (req_event_sequence),
      .req_payload_complete (req_payload_complete),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_command          (rsp_command),
      .rsp_command_sequence (rsp_command_sequence),
      .rsp_link_state       (rsp_link_state),
      .rsp_reset_request    (rsp_reset_request),
      .rsp_deliver_payload  (rsp_deliver_payload),
      .rsp_gap_seen         (rsp_gap_seen),
      .rsp_event_transaction(rsp_event_transaction),
      .rsp_stall_count      (rsp_stall_count),
      .csr_write            (csr_write),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   // Hands out the next command sequence number; it wraps at 16 bits.
   function automatic logic [15:0] take_cmd_seq();
      logic [15:0] s;
      s = model.next_cmd_seq;
      model.next_cmd_seq = model.next_cmd_seq + 16'd1;
      return s;
   endfunction

   // Extends the event sequence chain. A gap is anything but last plus one, once a
   // baseline exists; the comparison is done at 16 bits so that it wraps.
   function automatic logic chain_event_seq(input logic [15:0] seq);
      logic gap;
      gap = model.seq_known && ((model.last_evt_seq + 16'd1) != seq);
      model.last_evt_seq = seq;
      model.seq_known = 1'b1;
      return gap;
   endfunction

   // Works out the response beat of one accepted request and moves the session on.
   function automatic sls_pkg::result_type predict_session(input sls_pkg::item_type it);
      sls_pkg::result_type r;
      logic                forced, stalled, spurious, silent, evt;
      logic [31:0]         since_irq, since_evt, since_legal, since_hello, since_ping;
      r = '0;
      evt = 1'b0;
      case (it.operation)
         sls_pkg::OP_DECIDE: begin
            model.local_time = it.now_time;
            // All elapsed times are differences modulo 2^32.
            since_irq   = it.now_time - model.irq_high_since;
            since_evt   = it.now_time - model.last_event_time;
            since_legal = it.now_time - model.last_legal_time;
            since_hello = it.now_time - model.last_hello_time;
            since_ping  = it.now_time - model.last_ping_time;
            forced = 1'b0;
            if (model.link == sls_pkg::LINK_UP) begin
               stalled  = it.irq_level && (model.stall_counter >= model_cfg.stall_limit);
               spurious = it.irq_level && (model.irq_high_since != 32'd0) &&
                          (since_irq > model_cfg.spurious_irq_window) &&
                          (since_evt > model_cfg.spurious_irq_window);
               silent   = (model.irq_high_since == 32'd0) &&
                          (since_legal > model_cfg.silence_watchdog);
               if (stalled || spurious || silent) begin
                  model.link = sls_pkg::LINK_RECOVERY;
                  model.reset_pending = 1'b1;
                  forced = 1'b1;
               end
            end
            if (!forced) begin
               // A rise seen at time zero leaves the mark at zero, which reads as low.
               if (it.irq_level) begin
                  if (model.irq_high_since == 32'd0) model.irq_high_since = it.now_time;
               end else begin
                  model.irq_high_since = 32'd0;
                  model.stall_counter = 8'd0;
               end
               if (model.link == sls_pkg::LINK_WAIT) begin
                  if (model.hello_count >= model_cfg.hello_try_limit) begin
                     model.link = sls_pkg::LINK_RECOVERY;
                     model.reset_pending = 1'b1;
                  end else if (since_hello >= model_cfg.hello_retry_interval) begin
                     r.command = sls_pkg::CMD_HELLO;
                     r.command_sequence = take_cmd_seq();
                     model.last_hello_time = it.now_time;
                     model.hello_count = model.hello_count + 8'd1;
                  end
               end else if (model.link == sls_pkg::LINK_UP) begin
                  if (model.rf_query_pending) begin
                     r.command = sls_pkg::CMD_RF_QUERY;
                     r.command_sequence = take_cmd_seq();
                     model.rf_query_pending = 1'b0;
                  end else if (it.irq_level) begin
                     r.command = sls_pkg::CMD_IRQ_ACK;
                     r.command_sequence = take_cmd_seq();
                  end else if (since_ping >= model_cfg.ping_interval) begin
                     r.command = sls_pkg::CMD_PING;
                     r.command_sequence = take_cmd_seq();
                     model.last_ping_time = it.now_time;
                  end
               end
            end
         end
         sls_pkg::OP_DIGEST: begin
            model.local_time = model.local_time + it.transfer_time;
            if (it.frame_status == sls_pkg::STATUS_OK) begin
               model.last_legal_time = model.local_time;
               case (it.message_kind)
                  sls_pkg::MSG_HELLO: begin
                     if (it.body_valid) begin
                        model.hello_count = 8'd0;
                        if (model.link == sls_pkg::LINK_WAIT) begin
                           model.seq_known = 1'b0;
                           model.rf_query_pending = 1'b1;
                           model.stall_counter = 8'd0;
                           model.last_ping_time = model.local_time;
                           model.link = sls_pkg::LINK_UP;
                        end
                     end
                  end
                  sls_pkg::MSG_RX_DESC: begin
                     if (it.body_valid) begin
                        model.payload_delivered = 1'b0;
                        r.gap_seen = chain_event_seq(it.event_sequence);
                        evt = 1'b1;
                     end
                  end
                  sls_pkg::MSG_RX_CHUNK: begin
                     if (it.body_valid) begin
                        r.gap_seen = chain_event_seq(it.event_sequence);
                        evt = 1'b1;
                        if (!model.payload_delivered && it.payload_complete) begin
                           model.payload_delivered = 1'b1;
                           r.deliver_payload = 1'b1;
                        end
                     end
                  end
                  sls_pkg::MSG_QUEUE_FULL: begin
                     if (it.body_valid) begin
                        r.gap_seen = chain_event_seq(it.event_sequence);
                        evt = 1'b1;
                     end
                  end
                  // Asynchronous errors count as events but stay out of the sequence chain.
                  sls_pkg::MSG_ERROR:
                     evt = it.body_valid && (it.error_number >= sls_pkg::ASYNC_ERROR_MIN);
                  default: ;
               endcase
            end else if (it.frame_status == sls_pkg::STATUS_UNKNOWN_TYPE) begin
               model.last_legal_time = model.local_time;
            end
            if (evt) begin
               model.stall_counter = 8'd0;
               model.last_event_time = model.local_time;
            end else begin
               model.stall_counter = model.stall_counter + 8'd1;
            end
            r.event_transaction = evt;
         end
         sls_pkg::OP_RESET_DONE: begin
            model.reset_pending = 1'b0;
            model.link = sls_pkg::LINK_WAIT;
            model.hello_count = 8'd0;
            model.last_hello_time = it.now_time - model_cfg.hello_retry_interval;
            model.last_legal_time = it.now_time;
            model.seq_known = 1'b0;
            model.rf_query_pending = 1'b0;
            model.stall_counter = 8'd0;
            model.irq_high_since = 32'd0;
            model.local_time = it.now_time;
         end
         default: ;
      endcase
      r.link_state = model.link;
      r.reset_request = model.reset_pending;
      r.stall_count = model.stall_counter;
      return r;
   endfunction

   function automatic void check_field(input string label, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0h actual %0h", $time, label, want, got);
         fail_count++;
      end
   endfunction

   // Driver. A request beat is held while stalled; once it has moved, or when the
   // line is empty, the next beat is offered unless a random gap is taken. Each
   // accepted beat is run through the predictor at the edge that moves it.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) expected_rsp.push_back(predict_session(req_item));
         if (!req_valid || !req_stall) begin
            if (request_backlog.size() != 0 && $urandom_range(99) >= req_gap_pct) begin
               req_item <= request_backlog.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor. Every response beat that moves is matched against the oldest
   // expectation; the stall for the next cycle is drawn at the same edge.
   always @(posedge clock) begin
      sls_pkg::result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp.size() == 0) begin
               $display("%0t: response beat with no request behind it, command %0h",
                        $time, rsp_command);
               fail_count++;
            end else begin
               want = expected_rsp.pop_front();
               check_field("command", 32'(want.command), 32'(rsp_command));
               check_field("command_sequence", 32'(want.command_sequence),
                           32'(rsp_command_sequence));
               check_field("link_state", 32'(want.link_state), 32'(rsp_link_state));
               check_field("reset_request", 32'(want.reset_request), 32'(rsp_reset_request));
               check_field("deliver_payload", 32'(want.deliver_payload),
                           32'(rsp_deliver_payload));
               check_field("gap_seen", 32'(want.gap_seen), 32'(rsp_gap_seen));
               check_field("event_transaction", 32'(want.event_transaction),
                           32'(rsp_event_transaction));
               check_field("stall_count", 32'(want.stall_count), 32'(rsp_stall_count));
            end
         end
         rsp_stall <= ($urandom_range(99) < rsp_hold_pct);
      end
   end

   task automatic push_request(input logic [1:0] op, input logic [31:0] now,
                               input logic irq, input logic [31:0] txn,
                               input logic [3:0] status, input logic [2:0] kind,
                               input logic body, input logic [7:0] err,
                               input logic [15:0] seq, input logic complete);
      sls_pkg::item_type it;
      it.operation = op;
      it.now_time = now;
      it.irq_level = irq;
      it.transfer_time = txn;
      it.frame_status = status;
      it.message_kind = kind;
      it.body_valid = body;
      it.error_number = err;
      it.event_sequence = seq;
      it.payload_complete = complete;
      request_backlog.push_back(it);
   endtask

   // Random traffic shaped like real sessions: decides and digests dominate, most
   // digests are well-formed with a mostly consecutive event chain, hellos come
   // often enough to link, and reset-done beats pull the session out of recovery.
   task automatic queue_random_requests(input int unsigned count);
      logic [1:0]  op;
      logic [3:0]  status;
      logic [2:0]  kind;
      logic [7:0]  err;
      logic [31:0] txn;
      int unsigned pick;
      for (int unsigned n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 46) op = sls_pkg::OP_DECIDE;
         else if (pick < 92) op = sls_pkg::OP_DIGEST;
         else if (pick < 98) op = sls_pkg::OP_RESET_DONE;
         else op = OP_UNUSED;

         // Time mostly creeps forward; now and then it jumps anywhere or lands on zero.
         pick = $urandom_range(99);
         if (pick < 55) clock_us = clock_us + $urandom_range(2000);
         else if (pick < 90) clock_us = clock_us + $urandom_range(2000000);
         else if (pick < 97) clock_us = $urandom;
         else clock_us = 32'd0;

         pick = $urandom_range(99);
         if (pick < 72) status = sls_pkg::STATUS_OK;
         else if (pick < 82) status = sls_pkg::STATUS_UNKNOWN_TYPE;
         else status = 4'($urandom_range(15));

         pick = $urandom_range(99);
         if (pick < 20) kind = sls_pkg::MSG_HELLO;
         else if (pick < 35) kind = sls_pkg::MSG_RX_DESC;
         else if (pick < 60) kind = sls_pkg::MSG_RX_CHUNK;
         else if (pick < 70) kind = sls_pkg::MSG_QUEUE_FULL;
         else if (pick < 85) kind = sls_pkg::MSG_ERROR;
         else kind = 3'($urandom_range(7));

         err = $urandom_range(1) ? 8'($urandom_range(7)) : 8'($urandom_range(255));
         txn = ($urandom_range(99) < 80) ? $urandom_range(3000) : $urandom;
         seq_cursor = ($urandom_range(99) < 85) ? seq_cursor + 16'd1 : 16'($urandom);

         push_request(op, clock_us, 1'($urandom_range(1)), txn, status, kind,
                      $urandom_range(99) < 85, err, seq_cursor, $urandom_range(99) < 40);
      end
   endtask

   task automatic write_csr(input logic [2:0] index, input logic [31:0] data);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data <= data;
   endtask

   // Writes all six registers on back-to-back edges and mirrors them in the predictor.
   task automatic apply_settings(input sls_pkg::cfg_type c);
      write_csr(sls_pkg::REG_HELLO_RETRY_INTERVAL, c.hello_retry_interval);
      write_csr(sls_pkg::REG_HELLO_TRY_LIMIT, {24'd0, c.hello_try_limit});
      write_csr(sls_pkg::REG_STALL_LIMIT, {24'd0, c.stall_limit});
      write_csr(sls_pkg::REG_SPURIOUS_IRQ_WINDOW, c.spurious_irq_window);
      write_csr(sls_pkg::REG_SILENCE_WATCHDOG, c.silence_watchdog);
      write_csr(sls_pkg::REG_PING_INTERVAL, c.ping_interval);
      @(posedge clock);
      csr_write <= 1'b0;
      model_cfg = c;
   endtask

   // Waits, sampling away from the active edge, until every queued request has
   // moved and every response has come back, then lets the pipeline settle.
   task automatic wait_drained();
      forever begin
         @(negedge clock);
         if (request_backlog.size() == 0 && !req_valid && expected_rsp.size() == 0) break;
      end
      repeat (4) @(posedge clock);
   endtask

   function automatic sls_pkg::cfg_type random_settings();
      sls_pkg::cfg_type c;
      c.hello_retry_interval = $urandom_range(4000, 1);
      c.hello_try_limit      = 8'($urandom_range(12, 1));
      c.stall_limit          = 8'($urandom_range(10, 1));
      c.spurious_irq_window  = $urandom_range(2000000, 1);
      c.silence_watchdog     = $urandom_range(4000000, 1);
      c.ping_interval        = $urandom_range(1500000, 1);
      return c;
   endfunction

   initial begin
      sls_pkg::cfg_type c;
      model = '0;
      model.link = sls_pkg::LINK_WAIT;
      model.last_hello_time = 32'd0 - sls_pkg::HELLO_RETRY_INTERVAL_RESET;
      model_cfg = sls_pkg::CFG_RESET;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed walk through one session under the reset settings.
      req_gap_pct = 6;
      rsp_hold_pct = 48;
      // Hello with the IRQ line rising at time zero, then the answer that links.
      push_request(sls_pkg::OP_DECIDE, 32'd0, 1'b1, 32'd0, sls_pkg::STATUS_OK,
                   sls_pkg::MSG_HELLO, 1'b0, 8'd0, 16'd0, 1'b0);
      push_request(sls_pkg::OP_DIGEST, 32'd0, 1'b0, 32'd100, sls_pkg::STATUS_OK,
                   sls_pkg::MSG_HELLO, 1'b1, 8'd0, 16'd0, 1'b0);
      push_request(sls_pkg::OP_DECIDE, 32'd1000, 1'b0, 32'd0, sls_pkg::STATUS_OK,
                   sls_pkg::MSG_HELLO, 1'b0, 8'd0, 16'd0, 1'b0);
      // Event chain: baseline, a gap with a delivery, then the delivery held off.
      push_request(sls_pkg::OP_DIGEST, 32'd0, 1'b0, 32'd10, sls_pkg::STATUS_OK,
                   sls_pkg::MSG_RX_DESC, 1'b1, 8'd0, 16'd5, 1'b0);
      push_request(sls_pkg::OP_DIGEST, 32'd0, 1'b0, 32'd10, sls_pkg::STATUS_OK,
                   sls_pkg::MSG_RX_CHUNK, 1'b1, 8'd0, 16'd7, 1'b1);
      push_request(sls_pkg::OP_DIGEST, 32'd0, 1'b0, 32'd10, sls_pkg::STATUS_OK,
                   sls_pkg::MSG_RX_CHUNK, 1'b1, 8'd0, 16'd8, 1'b1);
      push_request(sls_pkg::OP_DIGEST, 32'd0, 1'b0, 32'd10, sls_pkg::STATUS_OK,
                   sls_pkg::MSG_QUEUE_FULL, 1'b1, 8'd0, 16'd9, 1'b0);
      // Error codes just below, at and far above the asynchronous threshold.
      push_request(sls_pkg::OP_DIGEST, 32'd0, 1'b0, 32'd10, sls_pkg::STATUS_OK,
                   sls_pkg::MSG_ERROR, 1'b1, 8'd3, 16'd0, 1'b0);
      push_request(sls_pkg::OP_DIGEST, 32'd0, 1'b0, 32'd10, sls_pkg::STATUS_OK,
                   sls_pkg::MSG_ERROR, 1'b1, 8'd4, 16'd0, 1'b0);
      push_request(sls_pkg::OP_DIGEST, 32'd0, 1'b0, 32'd10, sls_pkg::STATUS_OK,
                   sls_pkg::MSG_ERROR, 1'b1, 8'd255, 16'd0, 1'b0);
      // Unknown type, a status past the defined codes, kind seven and an invalid body.
      push_request(sls_pkg::OP_DIGEST, 32'd0, 1'b0, 32'd10, sls_pkg::STATUS_UNKNOWN_TYPE,
                   MSG_OTHER, 1'b1, 8'd0, 16'd0, 1'b0);
      push_request(sls_pkg::OP_DIGEST, 32'd0, 1'b0, 32'd10, STATUS_ILLEGAL_TOP,
                   MSG_UNDEFINED, 1'b1, 8'd0, 16'd0, 1'b0);
      push_request(sls_pkg::OP_DIGEST, 32'd0, 1'b0, 32'd10, sls_pkg::STATUS_OK,
                   MSG_UNDEFINED, 1'b1, 8'd0, 16'd0, 1'b0);
      push_request(sls_pkg::OP_DIGEST, 32'd0, 1'b0, 32'd10, sls_pkg::STATUS_OK,
                   sls_pkg::MSG_RX_CHUNK, 1'b0, 8'd0, 16'd10, 1'b1);
      // IRQ ack, then a ping once the interval has run out, then the unused code.
      push_request(sls_pkg::OP_DECIDE, 32'd2000, 1'b1, 32'd0, sls_pkg::STATUS_OK,
                   sls_pkg::MSG_HELLO, 1'b0, 8'd0, 16'd0, 1'b0);
      push_request(sls_pkg::OP_DECIDE, 32'd1100000, 1'b0, 32'd0, sls_pkg::STATUS_OK,
                   sls_pkg::MSG_HELLO, 1'b0, 8'd0, 16'd0, 1'b0);
      push_request(OP_UNUSED, 32'd5, 1'b1, 32'd5, sls_pkg::STATUS_OK,
                   sls_pkg::MSG_RX_CHUNK, 1'b1, 8'd0, 16'd11, 1'b1);
      // Silence watchdog, then traffic during recovery, then the restart.
      push_request(sls_pkg::OP_DECIDE, 32'hFFFF_FFFF, 1'b0, 32'd0, sls_pkg::STATUS_OK,
                   sls_pkg::MSG_HELLO, 1'b0, 8'd0, 16'd0, 1'b0);
      push_request(sls_pkg::OP_DECIDE, 32'hFFFF_FFFF, 1'b1, 32'd0, sls_pkg::STATUS_OK,
                   sls_pkg::MSG_HELLO, 1'b0, 8'd0, 16'd0, 1'b0);
      push_request(sls_pkg::OP_DIGEST, 32'd0, 1'b1, 32'd10, sls_pkg::STATUS_OK,
                   sls_pkg::MSG_RX_CHUNK, 1'b1, 8'd0, 16'd12, 1'b1);
      push_request(sls_pkg::OP_RESET_DONE, 32'hFFFF_FFFF, 1'b0, 32'd0, sls_pkg::STATUS_OK,
                   sls_pkg::MSG_HELLO, 1'b0, 8'd0, 16'd0, 1'b0);
      push_request(sls_pkg::OP_DECIDE, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, sls_pkg::STATUS_OK,
                   sls_pkg::MSG_HELLO, 1'b1, 8'hFF, 16'hFFFF, 1'b1);
      push_request(sls_pkg::OP_DIGEST, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, sls_pkg::STATUS_OK,
                   sls_pkg::MSG_ERROR, 1'b1, 8'hFF, 16'hFFFF, 1'b1);
      wait_drained();

      // Six random blocks, each under its own settings: the smallest values, the
      // largest, a moderate set, a random set, the reset values again and a second
      // random set. The first two blocks stall mostly on the response side, the
      // next two mostly on the request side, and the last two run without idling.
      for (int blk = 0; blk < 6; blk++) begin
         case (blk)
            0: c = '{32'd1, 8'd1, 8'd1, 32'd1, 32'd1, 32'd1};
            1: c = '{32'hFFFF_FFFF, 8'd255, 8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                     32'hFFFF_FFFF};
            2: c = '{32'd2000, 8'd3, 8'd4, 32'd5000, 32'd20000, 32'd3000};
            4: c = sls_pkg::CFG_RESET;
            default: c = random_settings();
         endcase
         apply_settings(c);
         req_gap_pct  = (blk < 2) ? 6 : (blk < 4) ? 48 : 0;
         rsp_hold_pct = (blk < 2) ? 48 : (blk < 4) ? 6 : 0;
         queue_random_requests(275);
         wait_drained();
      end

      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("spi_link_session_master regression: pass");
      end else begin
         $display("spi_link_session_master regression: fail");
      end
      $finish;
   end

   // Backstop in case the handshake locks up.
   initial begin
      #4000000;
      $display("spi_link_session_master regression: fail");
      $finish;
   end

endmodule
